### rtl/hbdt_pkg.sv
// Package for the H-bridge direction controller with dead time.
// Holds mode, phase and command codes, word structs and defaults; no dependencies.
`default_nettype none

package hbdt_pkg;

    // register and counter defaults
    localparam int          CFG_WIDTH         = 16;
    localparam int          COUNT_WIDTH_DEF   = 16;
    localparam logic [15:0] DEAD_TIME_RST     = 16'd100;

    // item opcodes
    typedef enum logic {
        OP_EVAL = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // motor modes
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STOP = 2'd1,
        MODE_FWD  = 2'd2,
        MODE_REV  = 2'd3
    } t_mode;

    // dead-time phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_RUN   = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // bridge commands
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STOP = 2'd1,
        ACT_FWD  = 2'd2,
        ACT_REV  = 2'd3
    } t_action;

    // input word
    typedef struct packed {
        logic       op;
        logic [1:0] wanted_mode;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [1:0] bridge_action;
        logic [1:0] present_mode;
        logic [1:0] dead_phase;
    } t_out_word;

endpackage

`default_nettype wire

### rtl/hbdt_ctrl.sv
// Mode and dead-time state machine with the millisecond down-counter.
// Depends on hbdt_pkg; state advances once per enabled word.
`default_nettype none

module hbdt_ctrl
    import hbdt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_in_word             i_word,
    input  wire logic [CFG_WIDTH-1:0] i_dead_time,
    output t_out_word                 o_word
);

    localparam int LW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [LW-1:0] CNT_MAX_EXT = LW'({COUNT_WIDTH{1'b1}});

    t_mode                  r_mode,  n_mode;
    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_rem,   n_rem;
    logic                   r_exp,   n_exp;

    t_action                act;
    t_mode                  want;
    t_phase                 ph_a;
    logic [COUNT_WIDTH-1:0] rem_a;
    logic                   exp_a;
    logic [LW-1:0]          dt_ext;
    logic [COUNT_WIDTH-1:0] load_val;

    // dead time saturated to the counter range
    assign dt_ext   = LW'(i_dead_time);
    assign load_val = (dt_ext > CNT_MAX_EXT) ? {COUNT_WIDTH{1'b1}}
                                             : dt_ext[COUNT_WIDTH-1:0];
    assign want     = t_mode'(i_word.wanted_mode);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_exp   <= 1'b0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_exp   <= n_exp;
        end
    end

    // dead-time advance as seen from the stop mode
    always_comb begin
        ph_a  = r_phase;
        rem_a = r_rem;
        exp_a = r_exp;
        if (r_phase == PH_IDLE || r_phase == PH_START) begin
            ph_a  = PH_RUN;
            rem_a = load_val;
            exp_a = (load_val == '0);
        end
        if (ph_a == PH_RUN && exp_a) begin
            ph_a  = PH_DONE;
            rem_a = '0;
            exp_a = 1'b0;
        end
    end

    // next state and command
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_exp   = r_exp;
        act     = ACT_NONE;
        if (t_op'(i_word.op) == OP_TICK) begin
            if (r_rem != '0) begin
                n_rem = r_rem - COUNT_WIDTH'(1);
                n_exp = (r_rem == COUNT_WIDTH'(1));
            end
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (want != MODE_IDLE) begin
                        act     = ACT_STOP;
                        n_mode  = MODE_STOP;
                        n_phase = PH_START;
                    end
                end
                MODE_STOP: begin
                    n_phase = ph_a;
                    n_rem   = rem_a;
                    n_exp   = exp_a;
                    if (want == MODE_IDLE) begin
                        act    = ACT_STOP;
                        n_mode = MODE_IDLE;
                    end else if ((want == MODE_FWD || want == MODE_REV)
                                 && ph_a == PH_DONE) begin
                        act    = t_action'(want);
                        n_mode = want;
                    end
                end
                MODE_FWD, MODE_REV: begin
                    if (want != r_mode) begin
                        act     = ACT_STOP;
                        n_mode  = (want == MODE_IDLE) ? MODE_IDLE : MODE_STOP;
                        n_phase = PH_START;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // result for this word
    assign o_word.bridge_action = act;
    assign o_word.present_mode  = n_mode;
    assign o_word.dead_phase    = n_phase;

endmodule

`default_nettype wire

### rtl/hbridge_direction_deadtime_fsm.sv
// Top level of the H-bridge direction controller with dead time.
// Depends on hbdt_pkg and hbdt_ctrl; holds the input and result registers.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+-----------------------------------
//  in      | in  | i_in_valid/o_in_stall | t_in_word: op, wanted_mode
//  out     | out | o_out_valid/i_out_stall| t_out_word: action, mode, phase
//  cfg     | in  | i_cfg_valid/o_cfg_ready| dead_time_ms, 16 bit
//
// One word per cycle while the result is not stalled; each word passes the input register, then the result register.
// The state update happens as a word moves from the input to the result register.
// Reset: mode idle, phase idle, counter zero, expiry clear, dead time 100 ticks.
// A stalled result holds; the input register still fills behind it, then stalls.
`default_nettype none

module hbridge_direction_deadtime_fsm
    import hbdt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_WIDTH-1:0] i_cfg_data
);

    logic                 r_in_valid;
    t_in_word             r_in_word;
    logic                 r_out_valid;
    t_out_word            r_out_word;
    logic [CFG_WIDTH-1:0] r_dead_time;
    logic                 adv;
    logic                 step;
    t_out_word            res_word;

    // pipeline advance
    assign adv        = !r_out_valid || !i_out_stall;
    assign step       = adv && r_in_valid;
    assign o_in_stall = r_in_valid && !adv;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time <= DEAD_TIME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dead_time <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // state machine
    hbdt_ctrl #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (step),
        .i_word     (r_in_word),
        .i_dead_time(r_dead_time),
        .o_word     (res_word)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### rtl/hbdt_checker.sv
// Port-level checks for the H-bridge direction controller, bound to the top level.
// Depends on hbdt_pkg.
`default_nettype none

module hbdt_checker
    import hbdt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word i_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_word))
        else $error("result word changed under stall");

    // driving only after completed dead time, into the driven mode
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.bridge_action == ACT_FWD
                        || i_out_word.bridge_action == ACT_REV)
        |-> i_out_word.present_mode == i_out_word.bridge_action
            && i_out_word.dead_phase == PH_DONE)
        else $error("drive without completed dead time");

    // a stop command leaves the bridge stopped or idle
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.bridge_action == ACT_STOP
        |-> i_out_word.present_mode == MODE_STOP
            || i_out_word.present_mode == MODE_IDLE)
        else $error("stop command with driven mode");

    // stopped mode always has a non-idle dead-time phase
    a_stop_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.present_mode == MODE_STOP
        |-> i_out_word.dead_phase != PH_IDLE)
        else $error("stopped mode with idle dead-time phase");

endmodule

bind hbridge_direction_deadtime_fsm hbdt_checker u_hbdt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_word (o_out_word)
);

`default_nettype wire
